### rtl/core/eth_l4p_pkg.sv
// types and constants shared by the ethernet / ipv4 / tcp-udp header parser
package eth_l4p_pkg;

   // input word: one frame byte plus end-of-frame mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   // result word: one per frame
   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] ether_type;
      logic [5:0]  ip_header_bytes;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] l4_info;
   } rsp_word_type;

   // status codes
   localparam logic [2:0] ST_TCP       = 3'd0;
   localparam logic [2:0] ST_UDP       = 3'd1;
   localparam logic [2:0] ST_OTHER     = 3'd2;
   localparam logic [2:0] ST_NON_IPV4  = 3'd3;
   localparam logic [2:0] ST_TRUNC_ETH = 3'd4;
   localparam logic [2:0] ST_TRUNC_IP  = 3'd5;
   localparam logic [2:0] ST_TRUNC_TCP = 3'd6;
   localparam logic [2:0] ST_TRUNC_UDP = 3'd7;

   // header constants
   localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [7:0]  ETH_LEN      = 8'd14;
   localparam logic [7:0]  IP_MIN_LEN   = 8'd20;
   localparam logic [7:0]  TCP_LEN      = 8'd20;
   localparam logic [7:0]  UDP_LEN      = 8'd8;
   localparam logic [6:0]  POS_MAX      = 7'd127;

   // fixed byte offsets in the frame, and the tcp flags offset within the transport header
   localparam logic [6:0] POS_IHL      = 7'd14;
   localparam logic [6:0] POS_TTL      = 7'd22;
   localparam logic [6:0] POS_PROTOCOL = 7'd23;
   localparam logic [6:0] REL_TCP_FLAGS = 7'd13;

endpackage

### rtl/core/eth_ipv4_l4_header_parser_top.sv
// ethernet / ipv4 / tcp-udp header parser, top level
// The parser takes a captured frame one byte per word, wire order, with
// last_byte set on the final byte, and sustains one byte per clock. Each byte
// is registered at the input, then header bytes are picked off into capture
// registers by a byte-position counter (saturating at 127). On the last byte
// one result word is formed that classifies the frame (tcp, udp, other
// protocol, non-ipv4, or truncated before ethernet, ip, tcp or udp); fields of
// layers not reached read as zero. Transport bytes are taken at offset
// 14 + 4*ihl even for ihl below five. A result is formed as its last byte
// leaves the input register and waits in the output register while rsp_stall is
// high; bytes of the next frame keep flowing in meanwhile, and the input only
// stalls when a second last byte meets a still-waiting result.
module eth_ipv4_l4_header_parser_top
   import eth_l4p_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         proceed;
   logic         req_accept;

   // capture state
   logic [6:0]  pos_ff, pos_in;
   logic [47:0] dst_mac_ff, dst_mac_in;
   logic [47:0] src_mac_ff, src_mac_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [31:0] src_ip_ff, src_ip_in;
   logic [31:0] dst_ip_ff, dst_ip_in;
   logic [47:0] transport_ff, transport_in;
   logic [7:0]  tcp_flags_ff, tcp_flags_in;

   // values after this byte is captured
   logic [47:0] cap_dst_mac, cap_src_mac, cap_transport;
   logic [15:0] cap_ether_type;
   logic [3:0]  cap_ihl;
   logic [7:0]  cap_ttl, cap_protocol, cap_tcp_flags;
   logic [31:0] cap_src_ip, cap_dst_ip;
   logic [7:0]  byte_val;
   logic [6:0]  tstart;
   logic [6:0]  rel;

   // result forming
   logic [7:0]   caplen;
   logic [7:0]   tstart_len;
   rsp_word_type result;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;

   // handshake
   assign proceed    = in_valid_ff &
                       (~in_word_ff.last_byte | ~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = in_valid_ff & ~proceed;
   assign req_accept = req_valid & ~req_stall;
   assign in_valid_in = req_accept | (in_valid_ff & ~proceed);

   // header byte capture
   always_comb begin
      byte_val       = in_word_ff.data_byte;
      cap_dst_mac    = dst_mac_ff;
      cap_src_mac    = src_mac_ff;
      cap_ether_type = ether_type_ff;
      cap_ihl        = ihl_ff;
      cap_ttl        = ttl_ff;
      cap_protocol   = protocol_ff;
      cap_src_ip     = src_ip_ff;
      cap_dst_ip     = dst_ip_ff;
      cap_transport  = transport_ff;
      cap_tcp_flags  = tcp_flags_ff;
      // positions are visited in order, so fields shift in msb first
      case (pos_ff) inside
         [7'd0:7'd5]: begin
            cap_dst_mac = {dst_mac_ff[39:0], byte_val};
         end
         [7'd6:7'd11]: begin
            cap_src_mac = {src_mac_ff[39:0], byte_val};
         end
         [7'd12:7'd13]: begin
            cap_ether_type = {ether_type_ff[7:0], byte_val};
         end
         POS_IHL: begin
            cap_ihl = byte_val[3:0];
         end
         POS_TTL: begin
            cap_ttl = byte_val;
         end
         POS_PROTOCOL: begin
            cap_protocol = byte_val;
         end
         [7'd26:7'd29]: begin
            cap_src_ip = {src_ip_ff[23:0], byte_val};
         end
         [7'd30:7'd33]: begin
            cap_dst_ip = {dst_ip_ff[23:0], byte_val};
         end
         default: begin
         end
      endcase
      // transport window, may overlap the ip header
      tstart = ETH_LEN[6:0] + {1'b0, cap_ihl, 2'b00};
      rel    = pos_ff - tstart;
      if (pos_ff >= tstart) begin
         if (rel < 7'd6) begin
            cap_transport = {transport_ff[39:0], byte_val};
         end else if (rel == REL_TCP_FLAGS) begin
            cap_tcp_flags = byte_val;
         end
      end
   end

   // state update, cleared after each last byte
   always_comb begin
      pos_in        = pos_ff;
      dst_mac_in    = dst_mac_ff;
      src_mac_in    = src_mac_ff;
      ether_type_in = ether_type_ff;
      ihl_in        = ihl_ff;
      ttl_in        = ttl_ff;
      protocol_in   = protocol_ff;
      src_ip_in     = src_ip_ff;
      dst_ip_in     = dst_ip_ff;
      transport_in  = transport_ff;
      tcp_flags_in  = tcp_flags_ff;
      if (proceed) begin
         if (in_word_ff.last_byte) begin
            pos_in        = '0;
            dst_mac_in    = '0;
            src_mac_in    = '0;
            ether_type_in = '0;
            ihl_in        = '0;
            ttl_in        = '0;
            protocol_in   = '0;
            src_ip_in     = '0;
            dst_ip_in     = '0;
            transport_in  = '0;
            tcp_flags_in  = '0;
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 7'd1;
            end
            dst_mac_in    = cap_dst_mac;
            src_mac_in    = cap_src_mac;
            ether_type_in = cap_ether_type;
            ihl_in        = cap_ihl;
            ttl_in        = cap_ttl;
            protocol_in   = cap_protocol;
            src_ip_in     = cap_src_ip;
            dst_ip_in     = cap_dst_ip;
            transport_in  = cap_transport;
            tcp_flags_in  = cap_tcp_flags;
         end
      end
   end

   // frame classification
   always_comb begin
      caplen     = {1'b0, pos_ff} + 8'd1;
      tstart_len = {1'b0, tstart};
      result     = '0;
      if (caplen < ETH_LEN) begin
         result.status = ST_TRUNC_ETH;
      end else begin
         result.dst_mac    = cap_dst_mac;
         result.src_mac    = cap_src_mac;
         result.ether_type = cap_ether_type;
         if (cap_ether_type != ETHTYPE_IPV4) begin
            result.status = ST_NON_IPV4;
         end else if (caplen < ETH_LEN + IP_MIN_LEN) begin
            result.status = ST_TRUNC_IP;
         end else begin
            result.ip_header_bytes = {cap_ihl, 2'b00};
            result.ttl             = cap_ttl;
            result.protocol        = cap_protocol;
            result.src_ip          = cap_src_ip;
            result.dst_ip          = cap_dst_ip;
            if (cap_protocol == PROTO_TCP) begin
               if (caplen < tstart_len + TCP_LEN) begin
                  result.status = ST_TRUNC_TCP;
               end else begin
                  result.status      = ST_TCP;
                  result.source_port = cap_transport[47:32];
                  result.dest_port   = cap_transport[31:16];
                  result.l4_info     = {8'd0, cap_tcp_flags};
               end
            end else if (cap_protocol == PROTO_UDP) begin
               if (caplen < tstart_len + UDP_LEN) begin
                  result.status = ST_TRUNC_UDP;
               end else begin
                  result.status      = ST_UDP;
                  result.source_port = cap_transport[47:32];
                  result.dest_port   = cap_transport[31:16];
                  result.l4_info     = cap_transport[15:0];
               end
            end else begin
               result.status = ST_OTHER;
            end
         end
      end
   end

   // output register
   assign rsp_valid_in = (proceed & in_word_ff.last_byte) | (rsp_valid_ff & rsp_stall);

   // control and capture registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         dst_mac_ff    <= '0;
         src_mac_ff    <= '0;
         ether_type_ff <= '0;
         ihl_ff        <= '0;
         ttl_ff        <= '0;
         protocol_ff   <= '0;
         src_ip_ff     <= '0;
         dst_ip_ff     <= '0;
         transport_ff  <= '0;
         tcp_flags_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
         dst_mac_ff    <= dst_mac_in;
         src_mac_ff    <= src_mac_in;
         ether_type_ff <= ether_type_in;
         ihl_ff        <= ihl_in;
         ttl_ff        <= ttl_in;
         protocol_ff   <= protocol_in;
         src_ip_ff     <= src_ip_in;
         dst_ip_ff     <= dst_ip_in;
         transport_ff  <= transport_in;
         tcp_flags_ff  <= tcp_flags_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_word;
      end
      if (proceed & in_word_ff.last_byte) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### rtl/core/eth_l4p_checker.sv
// port-level checks for the header parser, bound to the top level
module eth_l4p_checker
   import eth_l4p_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
   else $error("result word changed while stalled");

   // nothing past ethernet when the frame is too short for ethernet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_TRUNC_ETH |->
         rsp_word.dst_mac == '0 && rsp_word.src_mac == '0 &&
         rsp_word.ether_type == '0)
   else $error("ethernet fields set on a frame truncated before ethernet");

   // ip and transport fields stay zero when ip is not reached
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_NON_IPV4 || rsp_word.status == ST_TRUNC_IP) |->
         rsp_word.ip_header_bytes == '0 && rsp_word.ttl == '0 &&
         rsp_word.protocol == '0 && rsp_word.src_ip == '0 &&
         rsp_word.dst_ip == '0 && rsp_word.source_port == '0 &&
         rsp_word.dest_port == '0 && rsp_word.l4_info == '0)
   else $error("ip fields set on a frame without ip");

   // tcp results carry an ipv4 ethertype, a tcp or udp protocol and a zero upper l4_info byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == ST_TCP || rsp_word.status == ST_UDP) |->
         rsp_word.ether_type == ETHTYPE_IPV4 &&
         (rsp_word.protocol == PROTO_TCP || rsp_word.protocol == PROTO_UDP) &&
         rsp_word.l4_info[15:8] == '0 || rsp_word.status == ST_UDP)
   else $error("transport result inconsistent with ip header");

endmodule

bind eth_ipv4_l4_header_parser_top eth_l4p_checker u_eth_l4p_checker (.*);

### dv/eth_ipv4_l4_header_parser_top_test.sv
// self-checking testbench for the ethernet / ipv4 / tcp-udp header parser
module eth_ipv4_l4_header_parser_top_test;
   import eth_l4p_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int MAX_REPORTS    = 40;
   localparam int QUIET_TAIL     = 150;
   localparam int TOTAL_BYTES    = 1450;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   eth_ipv4_l4_header_parser_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // words waiting to be sent and headers waiting to come back
   req_word_type frame_bytes_pending[$];
   rsp_word_type expected_headers[$];

   // header capture state of the frame now streaming in
   logic [6:0]  parse_pos = '0;
   logic [47:0] cap_dst_mac = '0;
   logic [47:0] cap_src_mac = '0;
   logic [15:0] cap_ether_type = '0;
   logic [3:0]  cap_ihl = '0;
   logic [7:0]  cap_ttl = '0;
   logic [7:0]  cap_protocol = '0;
   logic [31:0] cap_src_ip = '0;
   logic [31:0] cap_dst_ip = '0;
   logic [47:0] cap_transport = '0;
   logic [7:0]  cap_tcp_flags = '0;

   int error_count = 0;
   int bytes_accepted = 0;
   int frames_queued = 0;
   int headers_checked = 0;
   int status_count[8];
   int send_gap = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   logic quiet_tail = 1'b0;
   rsp_word_type want;

   // bytes a frame needs to hold the whole transport header
   function automatic int l4_need(logic [3:0] ihl, logic [7:0] proto);
      return ETH_LEN + 4 * ihl + ((proto == PROTO_TCP) ? TCP_LEN : UDP_LEN);
   endfunction

   // capture one accepted byte; on the last byte queue the classified header
   task automatic track_header_byte(input req_word_type w);
      int unsigned pos;
      int unsigned caplen;
      int unsigned l4_start;
      int unsigned rel;
      rsp_word_type hdr;
      pos = 32'(parse_pos);
      if (pos < 6)
         cap_dst_mac[8 * (5 - pos) +: 8] = w.data_byte;
      else if (pos < 12)
         cap_src_mac[8 * (11 - pos) +: 8] = w.data_byte;
      else if (pos < 14)
         cap_ether_type[8 * (13 - pos) +: 8] = w.data_byte;
      else if (pos == POS_IHL)
         cap_ihl = w.data_byte[3:0];
      else if (pos == POS_TTL)
         cap_ttl = w.data_byte;
      else if (pos == POS_PROTOCOL)
         cap_protocol = w.data_byte;
      else if (pos >= 26 && pos < 30)
         cap_src_ip[8 * (29 - pos) +: 8] = w.data_byte;
      else if (pos >= 30 && pos < 34)
         cap_dst_ip[8 * (33 - pos) +: 8] = w.data_byte;

      // transport window sits at 14 + 4*ihl and may overlap the ip header
      l4_start = ETH_LEN + 4 * cap_ihl;
      if (pos >= l4_start) begin
         rel = pos - l4_start;
         if (rel < 6)
            cap_transport[8 * (5 - rel) +: 8] = w.data_byte;
         else if (rel == REL_TCP_FLAGS)
            cap_tcp_flags = w.data_byte;
      end

      if (!w.last_byte) begin
         if (parse_pos < POS_MAX)
            parse_pos = parse_pos + 7'd1;
         return;
      end

      // classify the frame; layers not reached stay zero
      caplen = pos + 1;
      hdr = '0;
      if (caplen < ETH_LEN) begin
         hdr.status = ST_TRUNC_ETH;
      end else begin
         hdr.dst_mac = cap_dst_mac;
         hdr.src_mac = cap_src_mac;
         hdr.ether_type = cap_ether_type;
         if (cap_ether_type != ETHTYPE_IPV4) begin
            hdr.status = ST_NON_IPV4;
         end else if (caplen < ETH_LEN + IP_MIN_LEN) begin
            hdr.status = ST_TRUNC_IP;
         end else begin
            hdr.ip_header_bytes = {cap_ihl, 2'b00};
            hdr.ttl = cap_ttl;
            hdr.protocol = cap_protocol;
            hdr.src_ip = cap_src_ip;
            hdr.dst_ip = cap_dst_ip;
            if (cap_protocol == PROTO_TCP || cap_protocol == PROTO_UDP) begin
               if (caplen < l4_need(cap_ihl, cap_protocol)) begin
                  hdr.status = (cap_protocol == PROTO_TCP) ? ST_TRUNC_TCP : ST_TRUNC_UDP;
               end else begin
                  hdr.source_port = cap_transport[47:32];
                  hdr.dest_port = cap_transport[31:16];
                  if (cap_protocol == PROTO_TCP) begin
                     hdr.status = ST_TCP;
                     hdr.l4_info = {8'h00, cap_tcp_flags};
                  end else begin
                     hdr.status = ST_UDP;
                     hdr.l4_info = cap_transport[15:0];
                  end
               end
            end else begin
               hdr.status = ST_OTHER;
            end
         end
      end
      expected_headers.push_back(hdr);

      parse_pos = '0;
      cap_dst_mac = '0;
      cap_src_mac = '0;
      cap_ether_type = '0;
      cap_ihl = '0;
      cap_ttl = '0;
      cap_protocol = '0;
      cap_src_ip = '0;
      cap_dst_ip = '0;
      cap_transport = '0;
      cap_tcp_flags = '0;
   endtask

   // build one frame with the given header fields over a fill pattern
   task automatic queue_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [7:0] proto, input fill_kind_type fill);
      req_word_type w;
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: w.data_byte = 8'h00;
            FILL_ONES: w.data_byte = 8'hFF;
            default:   w.data_byte = 8'($urandom);
         endcase
         if (i == 12)
            w.data_byte = etype[15:8];
         else if (i == 13)
            w.data_byte = etype[7:0];
         else if (i == POS_IHL)
            w.data_byte = {w.data_byte[7:4], ihl};
         else if (i == POS_PROTOCOL)
            w.data_byte = proto;
         w.last_byte = (i == len - 1);
         frame_bytes_pending.push_back(w);
      end
      frames_queued++;
   endtask

   task automatic check_field(input string name, input logic [47:0] exp_val,
                              input logic [47:0] got_val);
      if (exp_val !== got_val) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      end
   endtask

   // stimulus, reset and end of run
   initial begin : stimulus
      int pick;
      int sel;
      int len;
      int need;
      logic [15:0] etype;
      logic [3:0]  ihl;
      logic [7:0]  proto;

      // directed frames: thresholds, ihl extremes, all-zero / all-one bytes
      queue_frame(1, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_ONES);
      queue_frame(1, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_ZERO);
      queue_frame(13, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_ONES);
      queue_frame(14, 16'h86DD, 4'd5, PROTO_TCP, FILL_RANDOM);
      queue_frame(60, 16'hFFFF, 4'd15, 8'hFF, FILL_ONES);
      queue_frame(14, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
      queue_frame(33, ETHTYPE_IPV4, 4'd5, PROTO_UDP, FILL_RANDOM);
      queue_frame(34, ETHTYPE_IPV4, 4'd5, 8'd1, FILL_RANDOM);
      queue_frame(60, ETHTYPE_IPV4, 4'd15, 8'd0, FILL_ZERO);
      queue_frame(53, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
      queue_frame(54, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
      queue_frame(41, ETHTYPE_IPV4, 4'd5, PROTO_UDP, FILL_RANDOM);
      queue_frame(42, ETHTYPE_IPV4, 4'd5, PROTO_UDP, FILL_RANDOM);
      // ihl zero: transport starts on the ihl byte itself
      queue_frame(34, ETHTYPE_IPV4, 4'd0, PROTO_TCP, FILL_RANDOM);
      queue_frame(33, ETHTYPE_IPV4, 4'd0, PROTO_TCP, FILL_RANDOM);
      queue_frame(34, ETHTYPE_IPV4, 4'd0, PROTO_UDP, FILL_RANDOM);
      // small ihl: transport overlaps the ip header
      queue_frame(40, ETHTYPE_IPV4, 4'd2, PROTO_UDP, FILL_RANDOM);
      // largest ihl right at and below its thresholds
      queue_frame(93, ETHTYPE_IPV4, 4'd15, PROTO_TCP, FILL_RANDOM);
      queue_frame(94, ETHTYPE_IPV4, 4'd15, PROTO_TCP, FILL_ONES);
      queue_frame(81, ETHTYPE_IPV4, 4'd15, PROTO_UDP, FILL_RANDOM);
      queue_frame(82, ETHTYPE_IPV4, 4'd15, PROTO_UDP, FILL_RANDOM);
      // long frame past the position limit
      queue_frame(140, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
      // back-to-back one-byte frames
      queue_frame(1, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
      queue_frame(1, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
      queue_frame(1, ETHTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);

      // random frames, mostly tcp / udp near their length thresholds
      while (frame_bytes_pending.size() < TOTAL_BYTES) begin
         pick = $urandom_range(0, 99);
         ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(0, 15));
         proto = (pick < 40) ? PROTO_TCP : PROTO_UDP;
         etype = ETHTYPE_IPV4;
         need = l4_need(ihl, proto);
         if (need < ETH_LEN + IP_MIN_LEN)
            need = ETH_LEN + IP_MIN_LEN;
         if (pick < 70) begin
            sel = $urandom_range(0, 19);
            if (sel < 10)
               len = need + $urandom_range(0, 6);
            else if (sel < 15)
               len = need - $urandom_range(1, 3);
            else if (sel < 19)
               len = $urandom_range(14, need);
            else
               len = $urandom_range(need, 140);
         end else if (pick < 80) begin
            proto = 8'($urandom);
            len = $urandom_range(30, 50);
         end else if (pick < 90) begin
            etype = 16'($urandom);
            len = $urandom_range(14, 30);
         end else begin
            etype = 16'($urandom);
            ihl = 4'($urandom);
            proto = 8'($urandom);
            len = $urandom_range(1, 20);
         end
         queue_frame(len, etype, ihl, proto, FILL_RANDOM);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (frame_bytes_pending.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_headers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d frames in %0d bytes, %0d headers checked", frames_queued,
               bytes_accepted, headers_checked);
      $display("by status: tcp %0d udp %0d other %0d non-ipv4 %0d,",
               status_count[ST_TCP], status_count[ST_UDP], status_count[ST_OTHER],
               status_count[ST_NON_IPV4]);
      $display("   truncated eth %0d ip %0d tcp %0d udp %0d",
               status_count[ST_TRUNC_ETH], status_count[ST_TRUNC_IP],
               status_count[ST_TRUNC_TCP], status_count[ST_TRUNC_UDP]);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // byte driver with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_header_byte(req_word);
            bytes_accepted++;
         end
         quiet_tail <= (frame_bytes_pending.size() < QUIET_TAIL);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (frame_bytes_pending.size() != 0) begin
               req_word <= frame_bytes_pending.pop_front();
               req_valid <= 1'b1;
               if (!quiet_tail && $urandom_range(0, 11) == 0)
                  send_gap = $urandom_range(1, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // header monitor with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_headers.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected header word, expected none, got %0h", $time,
                           rsp_word);
            end else begin
               want = expected_headers.pop_front();
               headers_checked++;
               status_count[want.status]++;
               check_field("status", 48'(want.status), 48'(rsp_word.status));
               check_field("dst_mac", want.dst_mac, rsp_word.dst_mac);
               check_field("src_mac", want.src_mac, rsp_word.src_mac);
               check_field("ether_type", 48'(want.ether_type), 48'(rsp_word.ether_type));
               check_field("ip_header_bytes", 48'(want.ip_header_bytes),
                           48'(rsp_word.ip_header_bytes));
               check_field("ttl", 48'(want.ttl), 48'(rsp_word.ttl));
               check_field("protocol", 48'(want.protocol), 48'(rsp_word.protocol));
               check_field("src_ip", 48'(want.src_ip), 48'(rsp_word.src_ip));
               check_field("dst_ip", 48'(want.dst_ip), 48'(rsp_word.dst_ip));
               check_field("source_port", 48'(want.source_port),
                           48'(rsp_word.source_port));
               check_field("dest_port", 48'(want.dest_port), 48'(rsp_word.dest_port));
               check_field("l4_info", 48'(want.l4_info), 48'(rsp_word.l4_info));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: too long without any word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no word moved for %0d cycles, %0d headers outstanding",
                  $time, idle_cycles, expected_headers.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### sim.f
rtl/core/eth_l4p_pkg.sv
rtl/core/eth_ipv4_l4_header_parser_top.sv
rtl/core/eth_l4p_checker.sv
dv/eth_ipv4_l4_header_parser_top_test.sv
